// ===== design/kmst_pkg.sv =====
// shared widths and constants for the kruskal spanning tree engine
`default_nettype none

package kmst_pkg;

    localparam int VERTEX_W         = 6;
    localparam int WEIGHT_W         = 16;
    localparam int TOTAL_W          = 24;
    localparam int S_TDATA_W        = 32;
    localparam int M_TDATA_W        = 24;
    localparam int MAX_VERTICES_DEF = 64;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'h7F_FFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MIN = 24'h80_0000;

endpackage

`default_nettype wire

// ===== design/kruskal_mst_union_find.sv =====
// kruskal spanning tree engine: disjoint-set forest with union by size and path compression
//
// s_axis carries one edge per transfer, edges sorted by ascending weight; s_axis_tuser
// set on the first edge of a graph clears the forest and the running total before that
// edge, s_axis_tlast marks the final edge and comes back on m_axis_tlast.
// m_axis returns one result per edge: m_axis_tuser says the edge entered the tree,
// m_axis_tdata holds the saturated running weight of the tree.
// one edge at a time: the forest table has one write port and a registered read,
// and one sequencer walks the parent links of each endpoint in turn, one link per cycle,
// rewriting the nodes of each walk to point at their root, one write per cycle.
// an edge with both vertices in range runs a start, walk and path-rewrite step for each
// endpoint, then a decide step, a link step when the edge is taken, and an output step;
// s_axis_tready is high only between edges.
// an edge with first-edge set first runs a clearing pass over all MAX_VERTICES entries.
// after reset the block runs the same clearing pass before it
// raises s_axis_tready, with the total at zero.
// the result waits in an output register while m_axis_tready is low, and the next edge
// is taken meanwhile; only its own result then waits for the register to free up.
`default_nettype none

module kruskal_mst_union_find #(
    parameter int MAX_VERTICES = kmst_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // src_vertex, dst_vertex, edge_weight, zero pad
    input  wire logic [kmst_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // first_edge
    input  wire logic                           s_axis_tuser,
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tree_weight
    output logic [kmst_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // edge_taken
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);

    import kmst_pkg::*;

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int SW = $clog2(MAX_VERTICES + 1);

    typedef struct packed {
        logic          root;
        logic [SW-1:0] val;
    } entry_t;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_START  = 8'b0000_0100,
        S_WALK   = 8'b0000_1000,
        S_PATH   = 8'b0001_0000,
        S_DECIDE = 8'b0010_0000,
        S_LINK   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    entry_t mem [MAX_VERTICES];
    entry_t rd_data_reg;

    state_t              state_reg, state_next;
    logic [VW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                pend_reg, pend_next;
    logic                side_reg, side_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                m_valid_reg, m_valid_next;

    logic [VW-1:0]       a_reg, a_next;
    logic [VW-1:0]       b_reg, b_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic                last_reg, last_next;
    logic                range_reg, range_next;
    logic                taken_reg, taken_next;
    logic [VW-1:0]       cur_reg, cur_next;
    logic [VW-1:0]       x_reg, x_next;
    logic [VW-1:0]       root_reg, root_next;
    logic [VW-1:0]       ra_reg, ra_next;
    logic [VW-1:0]       rb_reg, rb_next;
    logic [SW-1:0]       sa_reg, sa_next;
    logic [SW-1:0]       sb_reg, sb_next;
    logic [VW-1:0]       link_root_reg, link_root_next;
    logic [SW-1:0]       size_sum_reg, size_sum_next;
    logic [TOTAL_W-1:0]  m_total_reg, m_total_next;
    logic                m_taken_reg, m_taken_next;
    logic                m_last_reg, m_last_next;

    logic                mem_we;
    logic [VW-1:0]       mem_waddr;
    entry_t              mem_wdata;
    logic [VW-1:0]       rd_addr;

    logic [VERTEX_W-1:0] in_src;
    logic [VERTEX_W-1:0] in_dst;
    logic [WEIGHT_W-1:0] in_weight;
    logic                in_range;
    logic [VW-1:0]       parent;
    logic [TOTAL_W:0]    total_sum;
    logic [TOTAL_W-1:0]  total_sat;
    logic [SW:0]         size_add;

    assign in_src    = s_axis_tdata[VERTEX_W-1:0];
    assign in_dst    = s_axis_tdata[2*VERTEX_W-1:VERTEX_W];
    assign in_weight = s_axis_tdata[2*VERTEX_W+WEIGHT_W-1:2*VERTEX_W];
    assign in_range  = ({{(32-VERTEX_W){1'b0}}, in_src} < 32'(MAX_VERTICES))
                    && ({{(32-VERTEX_W){1'b0}}, in_dst} < 32'(MAX_VERTICES));

    assign parent    = VW'(rd_data_reg.val);
    assign size_add  = {1'b0, sa_reg} + {1'b0, sb_reg};
    assign total_sum = {total_reg[TOTAL_W-1], total_reg}
                     + {{(TOTAL_W+1-WEIGHT_W){w_reg[WEIGHT_W-1]}}, w_reg};

    always_comb
    begin
        if (total_sum[TOTAL_W] != total_sum[TOTAL_W-1])
        begin
            total_sat = total_sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
        end
        else
        begin
            total_sat = total_sum[TOTAL_W-1:0];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_total_reg;
    assign m_axis_tuser  = m_taken_reg;
    assign m_axis_tlast  = m_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        pend_next      = pend_reg;
        side_next      = side_reg;
        total_next     = total_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        a_next         = a_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        last_next      = last_reg;
        range_next     = range_reg;
        taken_next     = taken_reg;
        cur_next       = cur_reg;
        x_next         = x_reg;
        root_next      = root_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        link_root_next = link_root_reg;
        size_sum_next  = size_sum_reg;
        m_total_next   = m_total_reg;
        m_taken_next   = m_taken_reg;
        m_last_next    = m_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_wdata      = '0;
        rd_addr        = cur_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = clr_cnt_reg;
                mem_wdata.root = 1'b1;
                mem_wdata.val  = SW'(1);
                if (clr_cnt_reg == VW'(MAX_VERTICES - 1))
                begin
                    clr_cnt_next = '0;
                    pend_next    = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (range_reg)
                    begin
                        state_next = S_START;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + VW'(1);
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    a_next     = VW'(in_src);
                    b_next     = VW'(in_dst);
                    w_next     = in_weight;
                    last_next  = s_axis_tlast;
                    range_next = in_range;
                    taken_next = 1'b0;
                    cur_next   = VW'(in_src);
                    side_next  = 1'b0;
                    if (s_axis_tuser)
                    begin
                        total_next = '0;
                        pend_next  = 1'b1;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = in_range ? S_START : S_OUT;
                    end
                end
            end
            S_START:
            begin
                rd_addr    = cur_reg;
                x_next     = cur_reg;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (rd_data_reg.root)
                begin
                    root_next = cur_reg;
                    if (side_reg)
                    begin
                        sb_next = rd_data_reg.val;
                    end
                    else
                    begin
                        sa_next = rd_data_reg.val;
                    end
                    rd_addr    = x_reg;
                    state_next = S_PATH;
                end
                else
                begin
                    cur_next = parent;
                    rd_addr  = parent;
                end
            end
            S_PATH:
            begin
                if (x_reg == root_reg)
                begin
                    if (side_reg)
                    begin
                        rb_next    = root_reg;
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        ra_next    = root_reg;
                        side_next  = 1'b1;
                        cur_next   = b_reg;
                        state_next = S_START;
                    end
                end
                else
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = x_reg;
                    mem_wdata.root = 1'b0;
                    mem_wdata.val  = SW'(root_reg);
                    x_next         = parent;
                    rd_addr        = parent;
                end
            end
            S_DECIDE:
            begin
                if (ra_reg == rb_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    taken_next     = 1'b1;
                    total_next     = total_sat;
                    size_sum_next  = size_add[SW-1:0];
                    mem_we         = 1'b1;
                    mem_wdata.root = 1'b0;
                    if (sa_reg < sb_reg)
                    begin
                        mem_waddr      = ra_reg;
                        mem_wdata.val  = SW'(rb_reg);
                        link_root_next = rb_reg;
                    end
                    else
                    begin
                        mem_waddr      = rb_reg;
                        mem_wdata.val  = SW'(ra_reg);
                        link_root_next = ra_reg;
                    end
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                mem_we         = 1'b1;
                mem_waddr      = link_root_reg;
                mem_wdata.root = 1'b1;
                mem_wdata.val  = size_sum_reg;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_total_next = total_reg;
                    m_taken_next = taken_reg;
                    m_last_next  = last_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // forest table, single write port and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            side_reg    <= 1'b0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
            side_reg    <= side_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        w_reg         <= w_next;
        last_reg      <= last_next;
        range_reg     <= range_next;
        taken_reg     <= taken_next;
        cur_reg       <= cur_next;
        x_reg         <= x_next;
        root_reg      <= root_next;
        ra_reg        <= ra_next;
        rb_reg        <= rb_next;
        sa_reg        <= sa_next;
        sb_reg        <= sb_next;
        link_root_reg <= link_root_next;
        size_sum_reg  <= size_sum_next;
        m_total_reg   <= m_total_next;
        m_taken_reg   <= m_taken_next;
        m_last_reg    <= m_last_next;
    end

    a_one_edge_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an edge is in flight");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK) |-> ({1'b0, size_sum_reg} <= (SW + 1)'(MAX_VERTICES)))
        else $error("merged tree larger than the vertex count");

    a_no_root_rewrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PATH && mem_we) |-> (x_reg != root_reg))
        else $error("path compression overwrote a root");

endmodule

`default_nettype wire
